// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m: lbl");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("%m: lbl");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: rtl/core/tmc_pkg.sv
package tmc_pkg;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned ACC_WIDTH   = 2 * VALUE_WIDTH + 2;

  typedef logic signed [VALUE_WIDTH-1:0] elem_t;

  typedef enum logic [2:0] {
    OP_IDENT   = 3'd0,
    OP_ZERO    = 3'd1,
    OP_WR_CUR  = 3'd2,
    OP_WR_OPND = 3'd3,
    OP_MUL     = 3'd4,
    OP_TRANS   = 3'd5,
    OP_SCALE   = 3'd6,
    OP_READ    = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_MUL,
    ST_COPY,
    ST_RD,
    ST_OUT
  } state_e;

  localparam elem_t ONE = elem_t'(64'(1) << FRAC_BITS);
endpackage

// File: rtl/core/transform_matrix_composer.sv
// Transform matrix composer.
// One input channel carries an opcode, an element index and x, y, z values;
// the output channel returns one beat per input beat: read_value_o (the
// element for a read, zero otherwise) and saturated_o (set when a multiply,
// translate or scale clipped an element sum).
// Both matrices live in 16-word synchronous memories. A compose reads one
// current-matrix word and one right-hand word per cycle into a single
// multiply-accumulate to build 16 result words in a scratch memory; a copy,
// which also absorbs the last sum and the read latency, then writes them
// back. Identity and zero sweep the current matrix before the output state;
// a read passes through a read state and a write goes straight to output.
// The result waits in the output register while the next beat is taken and
// processed; that beat then holds in its output cycle, with in_ready_o low,
// until the waiting result is taken, so a stalled receiver stalls the
// sender after one further beat.
// After reset a sweep over the 16 words loads identity into the current matrix and
// zero into the operand matrix; in_ready_o stays low meanwhile.
`include "assert_macros.svh"
module transform_matrix_composer import tmc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        opcode_i,
  input  logic [3:0]        element_index_i,
  input  logic signed [31:0] value_x_i,
  input  logic signed [31:0] value_y_i,
  input  logic signed [31:0] value_z_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic signed [31:0] read_value_o,
  output logic              saturated_o
);
  elem_t cur_mem [16];
  elem_t opd_mem [16];
  elem_t res_mem [16];

  state_e state_q, state_d;
  op_e    op_q;
  logic [3:0] idx_q;
  elem_t  x_q, y_q, z_q;
  logic [5:0] cnt_q, cnt_d;    // mul: {col,row,k}
  logic   rd_en_q;              // memory data valid this cycle
  logic [1:0] rd_k_q, rd_col_q, rd_row_q;
  logic   rd_last_q;
  elem_t  cur_rd_q, opd_rd_q, res_rd_q;
  logic signed [ACC_WIDTH-1:0] acc_q;
  logic   sat_q;
  logic   init_q;              // reset sweep in progress
  logic [3:0] cp_q;            // copy sweep delayed index

  logic acc_in;
  logic out_load;              // move the finished result into the output register
  assign in_ready_o = (state_q == ST_IDLE);
  assign acc_in = in_valid_i && in_ready_o;
  assign out_load = (state_q == ST_OUT) && (!out_valid_o || out_ready_i);

  // right-hand element at row k, column c
  function automatic elem_t rhs_sel(op_e op, logic [3:0] i, elem_t m,
                                    elem_t x, elem_t y, elem_t z);
    elem_t r;
    r = (i[3:2] == i[1:0]) ? ONE : '0;
    if (op == OP_TRANS) begin
      if (i == 4'd12) r = x;
      if (i == 4'd13) r = y;
      if (i == 4'd14) r = z;
    end else if (op == OP_SCALE) begin
      if (i == 4'd0) r = x;
      if (i == 4'd5) r = y;
      if (i == 4'd10) r = z;
    end else begin
      r = m;
    end
    return r;
  endfunction

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (acc_in) begin
          unique case (op_e'(opcode_i))
            OP_IDENT, OP_ZERO:            state_d = ST_INIT;
            OP_MUL, OP_TRANS, OP_SCALE:   state_d = ST_MUL;
            OP_READ:                      state_d = ST_RD;
            default:                      state_d = ST_OUT;
          endcase
        end
      end
      ST_INIT: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q[3:0] == 4'd15) state_d = init_q ? ST_IDLE : ST_OUT;
      end
      ST_MUL: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          state_d = ST_COPY;
          cnt_d   = '0;
        end
      end
      ST_COPY: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd17) state_d = ST_OUT;
      end
      ST_RD:   state_d = ST_OUT;
      // hold until the output register is free
      ST_OUT:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      cnt_q   <= '0;
      init_q  <= 1'b1;
      op_q    <= OP_IDENT;
      rd_en_q <= 1'b0;
      rd_last_q <= 1'b0;
      acc_q   <= '0;
      sat_q   <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == ST_INIT && cnt_q[3:0] == 4'd15) init_q <= 1'b0;
      if (acc_in) begin
        op_q <= op_e'(opcode_i);
        sat_q <= 1'b0;
      end
      rd_en_q   <= (state_q == ST_MUL);
      rd_last_q <= (state_q == ST_MUL) && (cnt_q[1:0] == 2'd3);
      // accumulate the product of the registered memory reads
      if (rd_en_q) begin
        logic signed [2*VALUE_WIDTH-1:0] p;
        logic signed [ACC_WIDTH-1:0] s;
        p = cur_rd_q * rhs_sel(op_q, {rd_col_q, rd_k_q}, opd_rd_q,
                               x_q, y_q, z_q);
        s = (rd_k_q == 2'd0 ? '0 : acc_q) + ACC_WIDTH'(p >>> FRAC_BITS);
        acc_q <= s;
        if (rd_last_q) begin
          if (s > ACC_WIDTH'(signed'({1'b0, {(VALUE_WIDTH-1){1'b1}}})) ||
              s < -(ACC_WIDTH'(1) <<< (VALUE_WIDTH-1))) sat_q <= 1'b1;
        end
      end
      if (out_load) out_valid_o <= 1'b1;
      else if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
    end
  end

  // payload and memories
  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      idx_q <= element_index_i;
      x_q <= value_x_i; y_q <= value_y_i; z_q <= value_z_i;
      if (op_e'(opcode_i) == OP_WR_CUR)  cur_mem[element_index_i] <= value_x_i;
      if (op_e'(opcode_i) == OP_WR_OPND) opd_mem[element_index_i] <= value_x_i;
    end
    if (state_q == ST_INIT) begin
      cur_mem[cnt_q[3:0]] <= (op_q == OP_IDENT && cnt_q[3:2] == cnt_q[1:0]) ? ONE : '0;
      if (init_q) opd_mem[cnt_q[3:0]] <= '0;
    end
    // mul: cnt = {col, row, k}; read cur[k*4+row], rhs[col*4+k]
    rd_k_q   <= cnt_q[1:0];
    rd_row_q <= cnt_q[3:2];
    rd_col_q <= cnt_q[5:4];
    cur_rd_q <= cur_mem[state_q == ST_MUL ? {cnt_q[1:0], cnt_q[3:2]} : idx_q];
    opd_rd_q <= opd_mem[{cnt_q[5:4], cnt_q[1:0]}];
    res_rd_q <= res_mem[cnt_q[3:0]];
    cp_q <= cnt_q[3:0];
    if (state_q == ST_COPY && cnt_q >= 6'd1 && cnt_q <= 6'd16)
      cur_mem[cp_q] <= res_rd_q;
    // load the result beat; hold it while the receiver stalls
    if (out_load) read_value_o <= (op_q == OP_READ) ? 32'(cur_rd_q) : '0;
    saturated_o <= out_load ? sat_q : saturated_o;
  end

  // Clipped result write: stage after accumulate, row/col from last read.
  logic wr_res_q;
  logic [3:0] wr_idx_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) wr_res_q <= 1'b0;
    else         wr_res_q <= rd_en_q && rd_last_q;
  end
  always_ff @(posedge clk_i) begin
    wr_idx_q <= {rd_col_q, rd_row_q};
    if (wr_res_q) begin
      res_mem[wr_idx_q] <=
        (acc_q > ACC_WIDTH'(signed'({1'b0, {(VALUE_WIDTH-1){1'b1}}}))) ?
          {1'b0, {(VALUE_WIDTH-1){1'b1}}} :
        (acc_q < -(ACC_WIDTH'(1) <<< (VALUE_WIDTH-1))) ?
          {1'b1, {(VALUE_WIDTH-1){1'b0}}} : acc_q[VALUE_WIDTH-1:0];
    end
  end

  `ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, (state_q != ST_IDLE) |-> !in_ready_o)
  `ASSERT_IMPL(a_out_after_done, clk_i, rst_ni, (state_q == ST_OUT) |=> out_valid_o)
  `ASSERT_IMPL(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(read_value_o) && $stable(saturated_o)))
  `ASSERT_NEVER(a_sat_only_compose, clk_i, rst_ni, sat_q && !(op_q == OP_MUL || op_q == OP_TRANS || op_q == OP_SCALE))
endmodule
